/* rtl/urrf_pkg.sv */
// Shared types, register map and helpers for the UART register block.
`default_nettype none

package urrf_pkg;

  // Receive FIFO depth (default for the top-level parameter).
  localparam int unsigned RX_DEPTH = 8;

  // Bus window and special read values.
  localparam logic [15:0] OFS_LIMIT     = 16'h1000;
  localparam logic [2:0]  MAX_SIZE      = 3'd4;
  localparam logic [31:0] RX_EMPTY_WORD = 32'h8000_0000;

  // Watermark count field: bits 18..16 of tx/rx control.
  localparam int unsigned WM_LSB = 16;
  localparam int unsigned WM_W   = 3;

  // Register offsets.
  localparam logic [15:0] REG_TX_DATA   = 16'h0000;
  localparam logic [15:0] REG_RX_DATA   = 16'h0004;
  localparam logic [15:0] REG_TX_CTRL   = 16'h0008;
  localparam logic [15:0] REG_RX_CTRL   = 16'h000C;
  localparam logic [15:0] REG_IRQ_EN    = 16'h0010;
  localparam logic [15:0] REG_IRQ_PEND  = 16'h0014;
  localparam logic [15:0] REG_DIVISOR   = 16'h0018;

  // Interrupt enable / pending bits.
  localparam int unsigned IRQ_TXWM = 0;
  localparam int unsigned IRQ_RXWM = 1;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_RX    = 2'd2
  } cmd_e;

  // FIFO control from the register decode.
  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctl_t;

  // Byte-lane mask for an access of the given size.
  function automatic logic [31:0] size_mask(input logic [2:0] size);
    logic [31:0] m;
    m = '0;
    for (int b = 0; b < 4; b++) begin
      if (size > 3'(b)) begin
        m[8*b +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

  // Byte-masked merge of write data into a register.
  function automatic logic [31:0] merge(input logic [31:0] cur, input logic [31:0] wd,
                                        input logic [31:0] mask);
    return (cur & ~mask) | (wd & mask);
  endfunction

endpackage

`default_nettype wire

/* rtl/urrf_in_if.sv */
// Input channel: bus commands and received line bytes.
`default_nettype none

interface urrf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] offset;
  logic [2:0]  access_size;
  logic [31:0] write_data;
  logic [7:0]  rx_byte;

  modport source (output valid, command, offset, access_size, write_data, rx_byte,
                  input ready);
  modport sink   (input valid, command, offset, access_size, write_data, rx_byte,
                  output ready);
endinterface

`default_nettype wire

/* rtl/urrf_out_if.sv */
// Output channel: one result per command.
`default_nettype none

interface urrf_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        access_ok;
  logic        bad_register;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic        rx_taken;
  logic        irq_level;

  modport source (output valid, read_data, access_ok, bad_register, tx_valid, tx_byte,
                  rx_taken, irq_level, input ready);
  modport sink   (input valid, read_data, access_ok, bad_register, tx_valid, tx_byte,
                  rx_taken, irq_level, output ready);
endinterface

`default_nettype wire

/* rtl/uart_regs_rx_fifo.sv */
// Top level: UART register block with receive FIFO, one result per command.
// Results are registered: each accepted command loads its result into the result register.
// Throughput: one command per cycle while the output is not stalled; decode, register update
//   and FIFO push/pop all complete at the accept edge, with the byte RAM read addressed by the next head.
// Reset (rst_ni, async low): FIFO empty, control words zero, no result pending.
//   FIFO RAM contents are not cleared; only written entries are ever returned.
`default_nettype none

module uart_regs_rx_fifo #(
  parameter int unsigned RxDepth = urrf_pkg::RX_DEPTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  urrf_in_if.sink   in_i,
  urrf_out_if.source out_o
);

  import urrf_pkg::*;

  localparam int unsigned FW = $clog2(RxDepth + 1);
  localparam int unsigned CW = (FW > WM_W) ? FW : WM_W;

  // Architectural registers
  logic [31:0] tx_ctrl_q,  tx_ctrl_d;
  logic [31:0] rx_ctrl_q,  rx_ctrl_d;
  logic [31:0] irq_en_q,   irq_en_d;
  logic [31:0] divisor_q,  divisor_d;

  // Result register
  logic        out_valid_q;
  logic [31:0] rd_q;
  logic        ok_q, bad_q, txv_q, taken_q, irq_q;
  logic [7:0]  txb_q;

  logic        in_fire;
  logic        is_read, is_write, is_rx, in_range;
  logic [31:0] mask;
  logic [31:0] rd_raw, rd_d;
  logic        bad_d, txv_d, taken_d, irq_d;
  logic [7:0]  txb_d;
  logic [1:0]  pend;
  logic [FW-1:0] fill, fill_next;
  logic [7:0]  head_byte;
  fifo_ctl_t   fifo_ctl;

  // The result register frees up when empty or when its transaction drains.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  assign is_read  = (in_i.command == CMD_READ);
  assign is_write = (in_i.command == CMD_WRITE);
  assign is_rx    = (in_i.command == CMD_RX);
  assign in_range = (in_i.offset < OFS_LIMIT) && (in_i.access_size <= MAX_SIZE);
  assign mask     = size_mask(in_i.access_size);

  // Interrupt pending: tx watermark when the tx count is nonzero,
  // rx watermark when the fill level exceeds the rx count.
  assign pend[IRQ_TXWM] = (tx_ctrl_q[WM_LSB +: WM_W] != '0);
  assign pend[IRQ_RXWM] = (CW'(fill) > CW'(rx_ctrl_q[WM_LSB +: WM_W]));

  // FIFO control. Push only with room; pop only a nonempty FIFO.
  assign fifo_ctl.push = in_fire && is_rx && (fill < FW'(RxDepth));
  assign fifo_ctl.pop  = in_fire && is_read && in_range && (in_i.offset == REG_RX_DATA)
                         && (fill != '0);

  always_comb begin
    fill_next = fill;
    if (fifo_ctl.push) begin
      fill_next = fill + FW'(1);
    end else if (fifo_ctl.pop) begin
      fill_next = fill - FW'(1);
    end
  end

  // Read mux and write decode
  always_comb begin
    rd_raw    = '0;
    bad_d     = 1'b0;
    txv_d     = 1'b0;
    txb_d     = '0;
    tx_ctrl_d = tx_ctrl_q;
    rx_ctrl_d = rx_ctrl_q;
    irq_en_d  = irq_en_q;
    divisor_d = divisor_q;
    if (is_read && in_range) begin
      unique case (in_i.offset)
        REG_TX_DATA:  rd_raw = '0;
        REG_RX_DATA:  rd_raw = (fill != '0) ? {24'h0, head_byte} : RX_EMPTY_WORD;
        REG_TX_CTRL:  rd_raw = tx_ctrl_q;
        REG_RX_CTRL:  rd_raw = rx_ctrl_q;
        REG_IRQ_EN:   rd_raw = irq_en_q;
        REG_IRQ_PEND: rd_raw = {30'h0, pend};
        REG_DIVISOR:  rd_raw = divisor_q;
        default:      bad_d  = 1'b1;
      endcase
    end else if (is_write && in_range) begin
      unique case (in_i.offset)
        REG_TX_DATA: begin
          txv_d = 1'b1;
          txb_d = in_i.write_data[7:0];
        end
        REG_TX_CTRL: tx_ctrl_d = merge(tx_ctrl_q, in_i.write_data, mask);
        REG_RX_CTRL: rx_ctrl_d = merge(rx_ctrl_q, in_i.write_data, mask);
        REG_IRQ_EN:  irq_en_d  = merge(irq_en_q, in_i.write_data, mask);
        REG_DIVISOR: divisor_d = merge(divisor_q, in_i.write_data, mask);
        default:     bad_d     = 1'b1;
      endcase
    end
  end

  assign rd_d    = rd_raw & mask;
  assign taken_d = fifo_ctl.push;
  // IRQ reflects the state left by this command.
  assign irq_d   = irq_en_d[IRQ_TXWM] || (irq_en_d[IRQ_RXWM] && (fill_next != '0));

  urrf_fifo #(
    .RxDepth (RxDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (fifo_ctl),
    .push_byte_i (in_i.rx_byte),
    .fill_o      (fill),
    .head_byte_o (head_byte)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_ctrl_q   <= '0;
      rx_ctrl_q   <= '0;
      irq_en_q    <= '0;
      divisor_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        tx_ctrl_q <= tx_ctrl_d;
        rx_ctrl_q <= rx_ctrl_d;
        irq_en_q  <= irq_en_d;
        divisor_q <= divisor_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload, loaded with each accepted transaction
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rd_q    <= rd_d;
      ok_q    <= (is_read || is_write) && in_range;
      bad_q   <= bad_d;
      txv_q   <= txv_d;
      txb_q   <= txb_d;
      taken_q <= taken_d;
      irq_q   <= irq_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.read_data    = rd_q;
  assign out_o.access_ok    = ok_q;
  assign out_o.bad_register = bad_q;
  assign out_o.tx_valid     = txv_q;
  assign out_o.tx_byte      = txb_q;
  assign out_o.rx_taken     = taken_q;
  assign out_o.irq_level    = irq_q;

  // Fill level never exceeds the FIFO depth.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill <= FW'(RxDepth))
    else $error("rx fill above depth");

  // Push and pop never coincide.
  a_push_pop_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fifo_ctl.push && fifo_ctl.pop))
    else $error("rx push and pop in same cycle");

  // An accepted command always yields a result next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted transaction produced no result");

  // A result flags at most one of transmit, receive push and unmapped access.
  a_result_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $onehot0({txv_q, taken_q, bad_q}))
    else $error("conflicting result flags");

  // A refused access returns no data and no unmapped flag.
  a_refused_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !ok_q) |-> (rd_q == '0 && !bad_q && !txv_q))
    else $error("refused access produced data");

endmodule

`default_nettype wire

/* rtl/urrf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module urrf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/urrf_fifo.sv */
// Receive FIFO: head/fill pointers around the byte RAM, head byte always ready.
`default_nettype none

module urrf_fifo #(
  parameter int unsigned RxDepth = urrf_pkg::RX_DEPTH
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire urrf_pkg::fifo_ctl_t          ctl_i,
  input  wire logic [7:0]                   push_byte_i,
  output logic [$clog2(RxDepth+1)-1:0]      fill_o,
  output logic [7:0]                        head_byte_o
);

  import urrf_pkg::*;

  localparam int unsigned IW = $clog2(RxDepth);
  localparam int unsigned FW = $clog2(RxDepth + 1);
  localparam int unsigned SW = IW + 1;

  logic [IW-1:0] head_q, head_d, head_inc, tail;
  logic [FW-1:0] fill_q, fill_d;
  logic [SW-1:0] tail_sum;
  logic [7:0]    ram_rdata;
  logic [7:0]    byp_q;
  logic          byp_sel_q;

  assign head_inc = (head_q == IW'(RxDepth - 1)) ? '0 : head_q + IW'(1);
  assign head_d   = ctl_i.pop ? head_inc : head_q;

  // tail = (head + fill) mod depth; the sum stays below twice the depth
  assign tail_sum = SW'(head_q) + SW'(fill_q);
  assign tail     = (tail_sum >= SW'(RxDepth)) ? IW'(tail_sum - SW'(RxDepth))
                                                : IW'(tail_sum);

  always_comb begin
    fill_d = fill_q;
    if (ctl_i.push) begin
      fill_d = fill_q + FW'(1);
    end else if (ctl_i.pop) begin
      fill_d = fill_q - FW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      fill_q    <= '0;
      byp_sel_q <= 1'b0;
    end else begin
      head_q    <= head_d;
      fill_q    <= fill_d;
      // only a push into an empty FIFO writes the entry being read
      byp_sel_q <= ctl_i.push && (fill_q == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    byp_q <= push_byte_i;
  end

  // Read address tracks the next head, so the registered data is the head byte.
  urrf_ram #(
    .Width (8),
    .Depth (RxDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_i.push),
    .waddr_i (tail),
    .wdata_i (push_byte_i),
    .raddr_i (head_d),
    .rdata_o (ram_rdata)
  );

  assign fill_o      = fill_q;
  assign head_byte_o = byp_sel_q ? byp_q : ram_rdata;

endmodule

`default_nettype wire
